// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker module of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, switched off while reset is held.
`define SLD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SLD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/sld_pkg.sv -----
`default_nettype none

package sld_pkg;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [1:0] REG_SYNC_PATTERN = 2'd0;
  localparam logic [1:0] REG_MIN_LEN      = 2'd1;
  localparam logic [1:0] REG_ENABLE       = 2'd2;

  localparam logic [7:0] MIN_LEN_RESET = 8'd5;

  typedef struct packed {
    logic [23:0] sync_pattern;
    logic [7:0]  min_packet_len;
    logic        enable;
  } sld_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic [7:0] packet_len;
  } sld_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/sync_length_deframer.sv -----
// Sync-word / length-prefixed packet deframer.
// The in_ stream carries one received byte per beat. While hunting, the
// block slides a SYNC_LEN-byte window over the stream; on a match with the
// sync word the next byte is the total packet length (header included).
// Lengths below min_packet_len, or too short to hold the header, are
// rejected and hunting goes on from the window ending on that length byte.
// Body bytes of an accepted packet leave on the out_ stream, one beat each,
// with tuser marking the first body byte and tlast the final one.
// Every byte is parsed by single-pass logic on the beat it is accepted, and
// a body beat is in the output register from the next cycle on. Throughput is
// one byte per cycle while the receiver keeps up, set by the single output
// register: in_tready is high whenever it is empty or is being drained.
// When the receiver stalls, the output beat holds and in_tready stays low
// for as long as it waits, whatever the next byte is: header and disabled
// bytes never need the register, yet still wait for in_tready.
// Reset clears the window, the parse state and the output register; the
// configuration registers return to sync word 0, minimum length 5 and
// parsing disabled (bytes are accepted and dropped).
`default_nettype none

module sync_length_deframer #(
  parameter int SYNC_LEN = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] out_byte, [15:8] packet_len
  output logic        out_tlast,   // last_of_packet
  output logic        out_tuser,   // [0] first_of_packet
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sld_pkg::*;

  sld_cfg_t    cfg;
  sld_result_t res;
  sld_result_t out_res;
  logic        res_valid;
  logic        can_take;
  logic        in_fire;

  sld_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_tready = can_take;
  assign in_fire   = in_tvalid && in_tready;

  sld_parser #(
    .SYNC_LEN (SYNC_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  sld_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire && res_valid),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.packet_len, out_res.out_byte};
  assign out_tlast = out_res.last_of_packet;
  assign out_tuser = out_res.first_of_packet;

endmodule

`default_nettype wire

// ----- rtl/core/sld_cfg_regs.sv -----
`default_nettype none

module sld_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sld_pkg::sld_cfg_t   cfg
);
  import sld_pkg::*;

  logic [23:0] sync_pattern_r;
  logic [7:0]  min_len_r;
  logic        enable_r;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_pattern_r <= 24'd0;
      min_len_r      <= MIN_LEN_RESET;
      enable_r       <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SYNC_PATTERN: sync_pattern_r <= pwdata[23:0];
        REG_MIN_LEN:      min_len_r      <= pwdata[7:0];
        REG_ENABLE:       enable_r       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYNC_PATTERN: prdata = {8'd0, sync_pattern_r};
      REG_MIN_LEN:      prdata = {24'd0, min_len_r};
      REG_ENABLE:       prdata = {31'd0, enable_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.sync_pattern   = sync_pattern_r;
  assign cfg.min_packet_len = min_len_r;
  assign cfg.enable         = enable_r;

endmodule

`default_nettype wire

// ----- rtl/core/sld_parser.sv -----
`default_nettype none

module sld_parser #(
  parameter int SYNC_LEN = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sld_pkg::sld_cfg_t    cfg,
  input  logic                 in_fire,
  input  logic [7:0]           in_byte,
  output logic                 res_valid,
  output sld_pkg::sld_result_t res
);
  import sld_pkg::*;

  localparam int WinW = 8 * SYNC_LEN;
  localparam int CntW = $clog2(SYNC_LEN + 1);
  localparam logic [CntW-1:0] SyncCnt = CntW'(SYNC_LEN);
  localparam logic [7:0] HdrLen = 8'(SYNC_LEN + 1);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  logic [1:0]      phase_r, phase_nxt;
  logic [WinW-1:0] win_r, win_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [7:0]      left_r, left_nxt;
  logic [7:0]      len_r, len_nxt;
  logic            first_r, first_nxt;

  logic [WinW+7:0]  win_cat;
  logic [WinW-1:0]  win_shift;
  logic [WinW+23:0] pat_wide;
  logic [CntW-1:0]  cnt_inc;
  logic             match;
  logic             len_bad;
  logic [7:0]       body_len;
  logic [7:0]       left_dec;

  // Sliding window and its compare. Sync bytes beyond the 24-bit register
  // compare with zero; a shorter window uses only the low pattern bytes.
  assign win_cat   = {win_r, in_byte};
  assign win_shift = win_cat[WinW-1:0];
  assign pat_wide  = {{WinW{1'b0}}, cfg.sync_pattern};
  assign cnt_inc   = (cnt_r == SyncCnt) ? cnt_r : cnt_r + 1'b1;
  assign match     = (cnt_inc == SyncCnt) && (win_shift == pat_wide[WinW-1:0]);

  assign len_bad   = (in_byte < cfg.min_packet_len) || (in_byte < HdrLen);
  assign body_len  = in_byte - HdrLen;
  assign left_dec  = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;

  assign res_valid           = cfg.enable && (phase_r == PH_BODY);
  assign res.out_byte        = in_byte;
  assign res.first_of_packet = first_r;
  assign res.last_of_packet  = (left_r == 8'd1);
  assign res.packet_len      = len_r;

  always_comb begin
    phase_nxt = phase_r;
    win_nxt   = win_r;
    cnt_nxt   = cnt_r;
    left_nxt  = left_r;
    len_nxt   = len_r;
    first_nxt = first_r;
    if (cfg.enable) begin
      case (phase_r)
        PH_LEN: begin
          if (len_bad) begin
            win_nxt   = win_shift;
            cnt_nxt   = cnt_inc;
            phase_nxt = match ? PH_LEN : PH_HUNT;
          end else begin
            len_nxt   = in_byte;
            left_nxt  = body_len;
            first_nxt = 1'b1;
            phase_nxt = PH_BODY;
            if (body_len == 8'd0) begin
              // Header only, no body: start over with an empty window.
              phase_nxt = PH_HUNT;
              win_nxt   = '0;
              cnt_nxt   = '0;
              first_nxt = 1'b0;
            end
          end
        end
        PH_BODY: begin
          first_nxt = 1'b0;
          left_nxt  = left_dec;
          if (left_dec == 8'd0) begin
            phase_nxt = PH_HUNT;
            win_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
        default: begin
          win_nxt   = win_shift;
          cnt_nxt   = cnt_inc;
          phase_nxt = match ? PH_LEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      win_r   <= '0;
      cnt_r   <= '0;
      left_r  <= 8'd0;
      len_r   <= 8'd0;
      first_r <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      win_r   <= win_nxt;
      cnt_r   <= cnt_nxt;
      left_r  <= left_nxt;
      len_r   <= len_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sld_out_stage.sv -----
`default_nettype none

module sld_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sld_pkg::sld_result_t res,
  output logic                 can_take,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output sld_pkg::sld_result_t out_res
);
  import sld_pkg::*;

  logic        valid_r, valid_nxt;
  sld_result_t data_r;

  // A new beat may enter when the register is empty or is drained this cycle.
  assign can_take = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = data_r;

endmodule

`default_nettype wire

// ----- rtl/core/sld_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module sld_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        out_tlast,
  input  logic        out_tuser
);

  // A stalled output beat keeps its payload.
  `SLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output beat changed")

  // The output register is empty right after reset.
  `SLD_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, !rst_n, !out_tvalid, "output valid after reset")

  // Input backpressure only comes from a stalled, full output register.
  `SLD_ASSERT_IMPL(a_stall_cause, clk, rst_n, !in_tready, out_tvalid && !out_tready, "input stalled without output stall")

  // A new output beat is always caused by an accepted input byte.
  `SLD_ASSERT_IMPL(a_out_cause, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready), "output beat without input beat")

endmodule

bind sync_length_deframer sld_checker u_sld_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
